// ===== rtl/core/dtoi_pkg.sv =====
// shared types, constants and limit functions for the decimal text converter
package dtoi_pkg;

  // default width of the consumed-character counter
  localparam int COUNT_BITS_DEF = 8;

  // configuration register indexes
  localparam logic [1:0] CFG_SIGNED_MODE  = 2'd0;
  localparam logic [1:0] CFG_RELAXED_MODE = 2'd1;
  localparam logic [1:0] CFG_NARROW_TO_32 = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // range limits on the magnitude
  localparam logic [63:0] LIM64_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LIM64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM64_UNS = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM32_NEG = 64'h0000_0000_8000_0000;
  localparam logic [63:0] LIM32_POS = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] LIM32_UNS = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_DIGITS  = 2'd1,
    PH_STOPPED = 2'd2,
    PH_FAILED  = 2'd3
  } phase_t;

  typedef struct packed {
    logic signed_mode;
    logic relaxed_mode;
    logic narrow_to_32;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic        is_negative;
    logic        saw_digit;
    logic [63:0] magnitude;
    logic [1:0]  held_status;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase:       PH_START,
    is_negative: 1'b0,
    saw_digit:   1'b0,
    magnitude:   64'd0,
    held_status: ST_OK
  };

  // 64-bit limit for the current sign and mode
  function automatic logic [63:0] lim64(input logic neg, input logic sgn);
    logic [63:0] lim;
    if (neg) begin
      lim = LIM64_NEG;
    end else if (sgn) begin
      lim = LIM64_POS;
    end else begin
      lim = LIM64_UNS;
    end
    return lim;
  endfunction

  // 32-bit narrowing limit for the current sign and mode
  function automatic logic [63:0] lim32(input logic neg, input logic sgn);
    logic [63:0] lim;
    if (neg) begin
      lim = LIM32_NEG;
    end else if (sgn) begin
      lim = LIM32_POS;
    end else begin
      lim = LIM32_UNS;
    end
    return lim;
  endfunction

endpackage

// ===== rtl/core/dtoi_step.sv =====
// one-character update of the parse state and the end-of-string result
module dtoi_step
  import dtoi_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  cfg_t                  cfg,
  input  parse_state_t          st,
  input  logic [COUNT_BITS-1:0] cnt,
  input  logic [7:0]            ch,
  output parse_state_t          st_nxt,
  output logic [COUNT_BITS-1:0] cnt_nxt,
  output logic                  res_fire,
  output logic [1:0]            res_status,
  output logic [63:0]           res_value
);

  logic                  is_nul;
  logic                  is_digit;
  logic                  is_blank;
  logic                  is_sign;
  logic [7:0]            dsub;
  logic [67:0]           acc;
  logic                  dig_ovf;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [63:0]           fin_lim64;
  logic [63:0]           fin_lim32;

  // character classes
  assign is_nul   = (ch == CH_NUL);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
  assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign dsub     = ch - CH_ZERO;

  // magnitude * 10 + digit, overflow when it passes the limit
  assign acc = 68'({st.magnitude, 3'b000}) + 68'({st.magnitude, 1'b0}) + 68'(dsub[3:0]);
  assign dig_ovf = acc > {4'b0000, lim64(st.is_negative, cfg.signed_mode)};

  // saturating counter bump
  assign cnt_inc = (cnt == {COUNT_BITS{1'b1}}) ? cnt : cnt + COUNT_BITS'(1);

  // limits checked again at the terminator with current registers
  assign fin_lim64 = lim64(st.is_negative, cfg.signed_mode);
  assign fin_lim32 = lim32(st.is_negative, cfg.signed_mode);

  // end-of-string result
  always_comb begin
    res_fire   = is_nul;
    res_value  = 64'd0;
    if (st.phase == PH_FAILED) begin
      res_status = st.held_status;
    end else if (!st.saw_digit) begin
      res_status = ST_INVALID;
    end else if (st.magnitude > fin_lim64) begin
      res_status = ST_OVERFLOW;
    end else if (cfg.narrow_to_32 && (st.magnitude > fin_lim32)) begin
      res_status = ST_OVERFLOW;
    end else begin
      res_status = ST_OK;
      res_value  = st.is_negative ? (64'd0 - st.magnitude) : st.magnitude;
    end
  end

  // next state for one character
  always_comb begin
    logic take_digit;
    st_nxt     = st;
    cnt_nxt    = cnt;
    take_digit = 1'b0;
    if (is_nul) begin
      st_nxt  = STATE_CLEAR;
      cnt_nxt = '0;
    end else begin
      unique case (st.phase)
        PH_START: begin
          if (cfg.relaxed_mode && is_blank) begin
            cnt_nxt = cnt_inc;
          end else if (cfg.signed_mode && is_sign) begin
            st_nxt.is_negative = (ch == CH_MINUS);
            st_nxt.phase       = PH_DIGITS;
            cnt_nxt            = cnt_inc;
          end else begin
            take_digit = 1'b1;
          end
        end
        PH_DIGITS: begin
          take_digit = 1'b1;
        end
        PH_STOPPED, PH_FAILED: begin
          st_nxt = st;
        end
        default: begin
          st_nxt = st;
        end
      endcase

      // digit accumulation, stop or failure
      if (take_digit) begin
        if (is_digit) begin
          if (dig_ovf) begin
            st_nxt.held_status = ST_OVERFLOW;
            st_nxt.phase       = PH_FAILED;
          end else begin
            st_nxt.magnitude = acc[63:0];
            st_nxt.saw_digit = 1'b1;
            st_nxt.phase     = PH_DIGITS;
            cnt_nxt          = cnt_inc;
          end
        end else if (cfg.relaxed_mode) begin
          st_nxt.phase = PH_STOPPED;
        end else begin
          st_nxt.held_status = ST_INVALID;
          st_nxt.phase       = PH_FAILED;
        end
      end
    end
  end

endmodule

// ===== rtl/core/decimal_text_to_integer.sv =====
// decimal text to integer converter top level
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   input   | in_valid, in_stall, in_text_char              | in
//   result  | out_valid, out_stall, out_parse_status,       | out
//           | out_parsed_value, out_used_count              |
//   config  | cfg_we, cfg_addr, cfg_wdata                   | in
//
// one character word is taken per cycle while in_stall is low; the rate is set by the single
// multiply-by-ten add and limit compare between the input and state registers.
// a result word enters the result register when its terminating NUL leaves the input register.
// rst_n (synchronous) clears the string state and loads the register defaults.
// in_stall rises only while a NUL waits behind a result word held by out_stall.
module decimal_text_to_integer
  import dtoi_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_parse_status,
  output logic [63:0] out_parsed_value,
  output logic [7:0]  out_used_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [0:0]  cfg_wdata
);

  cfg_t                  cfg_r;
  logic                  v_r;
  logic [7:0]            ch_r;
  parse_state_t          st_r;
  parse_state_t          st_nxt;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic                  res_fire;
  logic [1:0]            res_status;
  logic [63:0]           res_value;
  logic                  hold;
  logic                  fire;
  logic [15:0]           cnt_ext;
  logic [7:0]            cnt_sat;
  logic                  out_valid_r;
  logic [1:0]            status_r;
  logic [63:0]           value_r;
  logic [7:0]            used_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{signed_mode: 1'b1, relaxed_mode: 1'b1, narrow_to_32: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SIGNED_MODE:  cfg_r.signed_mode  <= cfg_wdata[0];
        CFG_RELAXED_MODE: cfg_r.relaxed_mode <= cfg_wdata[0];
        CFG_NARROW_TO_32: cfg_r.narrow_to_32 <= cfg_wdata[0];
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  // a NUL waits while the result register is full and stalled
  assign hold     = v_r && (ch_r == CH_NUL) && out_valid_r && out_stall;
  assign in_stall = hold;
  assign fire     = v_r && !hold;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!hold) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && in_valid) begin
      ch_r <= in_text_char;
    end
  end

  dtoi_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .cfg       (cfg_r),
    .st        (st_r),
    .cnt       (cnt_r),
    .ch        (ch_r),
    .st_nxt    (st_nxt),
    .cnt_nxt   (cnt_nxt),
    .res_fire  (res_fire),
    .res_status(res_status),
    .res_value (res_value)
  );

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= STATE_CLEAR;
      cnt_r <= '0;
    end else if (fire) begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // count saturated to the 8-bit output
  assign cnt_ext = 16'(cnt_r);
  assign cnt_sat = (cnt_ext > 16'd255) ? 8'hFF : cnt_ext[7:0];

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_fire) begin
      status_r <= res_status;
      value_r  <= res_value;
      used_r   <= cnt_sat;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_parse_status = status_r;
  assign out_parsed_value = value_r;
  assign out_used_count   = used_r;

  // a failed string always carries an error status
  a_failed_status: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_FAILED) |-> (st_r.held_status != ST_OK))
    else $error("failed phase without error status");

  // error results carry a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_OK)) |-> (value_r == 64'd0))
    else $error("nonzero value on error result");

  // a new result word only follows a NUL
  a_result_from_nul: assert property (@(posedge clk) disable iff (!rst_n)
    (!(v_r && (ch_r == CH_NUL)) && !out_stall) |=> !out_valid_r)
    else $error("result word without a terminator");

  // input stall only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && v_r))
    else $error("input stalled without a blocked result");

endmodule
